// ===== hw/rtl/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// Used by the parser front end, the result queue, the output stage and the top level.
`timescale 1ns / 1ps

package wsd_pkg;

    // Default depth of the queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 4;

    // Opcode of a continuation frame.
    localparam logic [3:0] OP_CONT = 4'h0;

    // Seven-bit length codes that announce an extended length field.
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Extended length field sizes in bytes.
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    // Last index of the four masking key bytes.
    localparam logic [3:0] KEY_LAST = 4'd3;

    // Status codes of a result.
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_OPEN         = 2'd1;
    localparam logic [1:0] ST_NO_OPEN      = 2'd2;
    localparam logic [1:0] ST_KEY_MISMATCH = 2'd3;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_LEN     = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    // One classified result, as queued between the parser and the output stage.
    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  key_byte;
        logic        has_byte;
        logic [3:0]  opcode;
        logic        eom;
        logic [31:0] key;
        logic [1:0]  status;
    } cmd_t;

endpackage

// ===== hw/rtl/wsd_front.sv =====
// Parser front end of the WebSocket frame deframer: header decode, message rules.
// Depends on wsd_pkg; feeds classified results to wsd_queue.
`timescale 1ns / 1ps

module wsd_front
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output logic       push,
    output cmd_t       cmd
);

    phase_t      phase_reg,       phase_next;
    logic [3:0]  hbc_reg,         hbc_next;
    logic        final_reg,       final_next;
    logic [3:0]  opcode_reg,      opcode_next;
    logic        masked_reg,      masked_next;
    logic [63:0] left_reg,        left_next;
    logic [31:0] key_reg,         key_next;
    logic [1:0]  kbi_reg,         kbi_next;
    logic        open_reg,        open_next;
    logic [3:0]  open_op_reg,     open_op_next;
    logic [31:0] open_key_reg,    open_key_next;
    logic        halted_reg,      halted_next;

    logic        after_len;
    logic        hdr_done;
    logic [1:0]  st;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            hbc_reg      <= '0;
            final_reg    <= 1'b0;
            opcode_reg   <= '0;
            masked_reg   <= 1'b0;
            left_reg     <= '0;
            key_reg      <= '0;
            kbi_reg      <= '0;
            open_reg     <= 1'b0;
            open_op_reg  <= '0;
            open_key_reg <= '0;
            halted_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hbc_reg      <= hbc_next;
            final_reg    <= final_next;
            opcode_reg   <= opcode_next;
            masked_reg   <= masked_next;
            left_reg     <= left_next;
            key_reg      <= key_next;
            kbi_reg      <= kbi_next;
            open_reg     <= open_next;
            open_op_reg  <= open_op_next;
            open_key_reg <= open_key_next;
            halted_reg   <= halted_next;
        end
    end

    // Next state and the result of the accepted byte.
    always_comb
    begin
        phase_next    = phase_reg;
        hbc_next      = hbc_reg;
        final_next    = final_reg;
        opcode_next   = opcode_reg;
        masked_next   = masked_reg;
        left_next     = left_reg;
        key_next      = key_reg;
        kbi_next      = kbi_reg;
        open_next     = open_reg;
        open_op_next  = open_op_reg;
        open_key_next = open_key_reg;
        halted_next   = halted_reg;
        push          = 1'b0;
        cmd           = '0;
        after_len     = 1'b0;
        hdr_done      = 1'b0;
        st            = ST_OK;

        if (accept && !halted_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    final_next  = in_byte[7];
                    opcode_next = in_byte[3:0];
                    phase_next  = PH_LEN;
                end
                PH_LEN:
                begin
                    masked_next = in_byte[7];
                    if (in_byte[6:0] < LEN_EXT16)
                    begin
                        left_next = {57'b0, in_byte[6:0]};
                        after_len = 1'b1;
                    end
                    else
                    begin
                        left_next  = '0;
                        hbc_next   = (in_byte[6:0] == LEN_EXT64) ? EXT64_BYTES : EXT16_BYTES;
                        phase_next = PH_EXTLEN;
                    end
                end
                PH_EXTLEN:
                begin
                    left_next = {left_reg[55:0], in_byte};
                    hbc_next  = hbc_reg - 4'd1;
                    if (hbc_next == 4'd0)
                    begin
                        after_len = 1'b1;
                    end
                end
                PH_KEY:
                begin
                    // The first key byte lands in the least significant byte.
                    key_next = key_reg | ({24'b0, in_byte} << {hbc_reg[1:0], 3'b000});
                    hbc_next = hbc_reg + 4'd1;
                    if (hbc_reg >= KEY_LAST)
                    begin
                        hbc_next = '0;
                        hdr_done = 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    kbi_next         = kbi_reg + 2'd1;
                    left_next        = left_reg - 64'd1;
                    push             = 1'b1;
                    cmd.data         = in_byte;
                    cmd.key_byte     = key_reg[{kbi_reg, 3'b000} +: 8];
                    cmd.has_byte     = 1'b1;
                    cmd.opcode       = open_op_reg;
                    if (left_next == 64'd0)
                    begin
                        phase_next = PH_HDR0;
                        if (final_reg)
                        begin
                            cmd.eom       = 1'b1;
                            cmd.key       = key_reg;
                            open_next     = 1'b0;
                            open_op_next  = '0;
                            open_key_next = '0;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase

            // Length complete: collect a masking key or finish the header.
            if (after_len)
            begin
                key_next = '0;
                if (masked_next)
                begin
                    phase_next = PH_KEY;
                    hbc_next   = '0;
                end
                else
                begin
                    hdr_done = 1'b1;
                end
            end

            // Header complete: apply the fragmentation rules.
            if (hdr_done)
            begin
                if (opcode_reg != OP_CONT)
                begin
                    if (open_reg)
                    begin
                        st = ST_OPEN;
                    end
                end
                else if (!open_reg)
                begin
                    st = ST_NO_OPEN;
                end
                else if (open_key_reg != key_next)
                begin
                    st = ST_KEY_MISMATCH;
                end

                if (st != ST_OK)
                begin
                    halted_next = 1'b1;
                    push        = 1'b1;
                    cmd.opcode  = opcode_reg;
                    cmd.status  = st;
                end
                else
                begin
                    if (opcode_reg != OP_CONT)
                    begin
                        open_next     = 1'b1;
                        open_op_next  = opcode_reg;
                        open_key_next = key_next;
                    end
                    kbi_next = '0;
                    if (left_next == 64'd0)
                    begin
                        phase_next = PH_HDR0;
                        if (final_reg)
                        begin
                            push          = 1'b1;
                            cmd.opcode    = open_op_next;
                            cmd.eom       = 1'b1;
                            cmd.key       = key_next;
                            open_next     = 1'b0;
                            open_op_next  = '0;
                            open_key_next = '0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
        end
    end

    // Once halted, the parser stays halted until reset.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("parser left the halted state without reset");

    // An error result always halts the parser.
    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && cmd.status != ST_OK) |=> halted_reg)
        else $error("error result without halt");

    // Nothing is produced after a halt.
    a_no_push_halted: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !push)
        else $error("result produced while halted");

endmodule

// ===== hw/rtl/wsd_queue.sv =====
// Short result queue between the parser front end and the output stage.
// Depends on wsd_pkg for the queued result type.
`timescale 1ns / 1ps

module wsd_queue
    import wsd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

endmodule

// ===== hw/rtl/wsd_back.sv =====
// Output stage of the WebSocket frame deframer: unmasking and result register.
// Depends on wsd_pkg; drains wsd_queue into the output channel.
`timescale 1ns / 1ps

module wsd_back
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        report_key_mode,
    input  logic        head_valid,
    input  cmd_t        head_cmd,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        has_byte,
    output logic [3:0]  msg_opcode,
    output logic        end_of_message,
    output logic [31:0] message_key,
    output logic [1:0]  status
);

    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg;
    logic        has_reg;
    logic [3:0]  op_reg;
    logic        eom_reg;
    logic [31:0] key_reg;
    logic [1:0]  st_reg;

    // Load a new result when the register is empty or being taken.
    assign pop        = head_valid && (!valid_reg || !out_stall);
    assign valid_next = pop || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register; the key byte is applied here.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_reg <= head_cmd.data ^ head_cmd.key_byte;
            has_reg  <= head_cmd.has_byte;
            op_reg   <= head_cmd.opcode;
            eom_reg  <= head_cmd.eom;
            key_reg  <= report_key_mode ? head_cmd.key : 32'd0;
            st_reg   <= head_cmd.status;
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign has_byte       = has_reg;
    assign msg_opcode     = op_reg;
    assign end_of_message = eom_reg;
    assign message_key    = key_reg;
    assign status         = st_reg;

endmodule

// ===== hw/rtl/websocket_frame_deframer.sv =====
// WebSocket receive deframer: parser front end, result queue and output stage.
// Instantiates wsd_front, wsd_queue and wsd_back; depends on wsd_pkg.
//
// Usage:
//   Input channel (in_valid, in_stall, in_byte) takes the raw stream one byte per
//   transaction. Header bytes give no result; each payload byte gives one result
//   with the unmasked byte; a zero-length final frame gives one empty result that
//   closes the message; a protocol error gives one status result and halts the
//   parser until reset.
//   Output channel (out_valid, out_stall, result fields) delivers the results.
//   Configuration channel (cfg_valid, cfg_ready, cfg_data) writes report_key_mode;
//   cfg_ready is always high. Write it only while no results are pending.
//   Throughput: one byte per cycle, every cycle, while the output is not stalled.
//   Each result passes through the queue and then the output register before it
//   appears on the output.
//   Stalling the output fills the queue (QUEUE_DEPTH results plus the output
//   register); in_stall rises only when the queue is full.
//   Reset clears the parser, the queue and the output valid; report_key_mode
//   returns to zero.
`timescale 1ns / 1ps

module websocket_frame_deframer
    import wsd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        has_byte,
    output logic [3:0]  msg_opcode,
    output logic        end_of_message,
    output logic [31:0] message_key,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic mode_reg, mode_next;
    logic accept;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic head_valid;
    cmd_t head_cmd;
    logic pop;

    // Configuration register.
    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? cfg_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // Input transaction.
    assign in_stall = full;
    assign accept   = in_valid && !in_stall;

    wsd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .push    (push),
        .cmd     (push_cmd)
    );

    wsd_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    wsd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .report_key_mode (mode_reg),
        .head_valid      (head_valid),
        .head_cmd        (head_cmd),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .has_byte        (has_byte),
        .msg_opcode      (msg_opcode),
        .end_of_message  (end_of_message),
        .message_key     (message_key),
        .status          (status)
    );

    // The queue is never written while it reports full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("result written into a full queue");

    // A result that is stalled on the output keeps its payload.
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(status)))
        else $error("stalled result changed");

    // The output stage only draws from a non-empty queue.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("read from an empty queue");

endmodule
